/* hw/rtl/fractional_clock_divider_setting_macros.svh */
// ----------------------------------------------------------------------------
// Fractional clock divider setting: assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_CLOCK_DIVIDER_SETTING_MACROS_SVH
`define FRACTIONAL_CLOCK_DIVIDER_SETTING_MACROS_SVH

// Check cons in the same cycle as ante.
`define FCDS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define FCDS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fcds_pkg.sv */
// ----------------------------------------------------------------------------
// Fractional clock divider setting: package
// Types, codes and widths shared by the sequencer, divider and top level.
// ----------------------------------------------------------------------------
package fcds_pkg;

    localparam int DIV_W      = 56;
    localparam int DIV_CNT_W  = 6;
    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 96;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [4:0] FIELD_MAX_W = 5'd16;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_INT_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAC_WIDTH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INT_SHIFT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAC_SHIFT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_BASED = 3'd4;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_RECALC = 2'd1,
        ACT_SET    = 2'd2,
        ACT_NONE   = 2'd3
    } fcds_action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WAIT_Q,
        ST_WAIT_T,
        ST_ADJ,
        ST_PACK,
        ST_WAIT_F,
        ST_WAIT_R,
        ST_OUT
    } fcds_state_t;

    typedef struct packed {
        logic [4:0] int_width;
        logic [4:0] frac_width;
        logic [4:0] int_shift;
        logic [4:0] frac_shift;
        logic       zero_based;
    } fcds_cfg_t;

    typedef struct packed {
        fcds_action_t action;
        logic [39:0]  parent_freq;
        logic [39:0]  target_freq;
        logic [31:0]  reg_in;
        logic         round_up;
        logic         round_down;
        logic         test_run;
    } fcds_item_t;

    typedef struct packed {
        logic [55:0] freq_out;
        logic [1:0]  status;
        logic        not_clamped;
        logic [31:0] reg_out;
        logic        reg_write;
    } fcds_result_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } fcds_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } fcds_div_rsp_t;

endpackage

/* hw/rtl/fcds_div.sv */
// ----------------------------------------------------------------------------
// Fractional clock divider setting: shared divider
// Restoring radix-2 divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
`include "fractional_clock_divider_setting_macros.svh"

module fcds_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fcds_pkg::fcds_div_req_t req,
    output fcds_pkg::fcds_div_rsp_t rsp
);
    import fcds_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quot_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dsor_reg;

    logic [DIV_W:0]       rem_shift;
    logic [DIV_W:0]       rem_diff;
    logic                 fits;

    assign rem_shift = {rem_reg, quot_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsor_reg};
    assign fits      = rem_shift >= {1'b0, dsor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            dsor_reg <= req.divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
            rem_reg  <= fits ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

    `FCDS_ASSERT_NOW(a_no_restart, aclk, aresetn, req.start, !busy_reg, "restart while busy")
    `FCDS_ASSERT_NEXT(a_start_busy, aclk, aresetn, req.start, busy_reg && !done_reg, "start lost")
    `FCDS_ASSERT_NOW(a_done_idle, aclk, aresetn, done_reg, !busy_reg, "done while busy")

endmodule

/* hw/rtl/fcds_ctrl.sv */
// ----------------------------------------------------------------------------
// Fractional clock divider setting: sequencer
// Holds the divider state; load sets it, recalc and set use the shared divider.
// ----------------------------------------------------------------------------
module fcds_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fcds_pkg::fcds_cfg_t     cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  fcds_pkg::fcds_item_t    in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output fcds_pkg::fcds_result_t  out_result,
    output fcds_pkg::fcds_div_req_t div_req,
    input  fcds_pkg::fcds_div_rsp_t div_rsp
);
    import fcds_pkg::*;

    fcds_state_t  state_reg, state_next;
    logic [32:0]  divider_reg, divider_next;

    fcds_action_t action_reg;
    logic [39:0]  target_reg;
    logic [31:0]  reg_in_reg;
    logic         rup_reg, rdn_reg, test_reg;
    logic [55:0]  fin_reg;
    logic [56:0]  d_reg;
    logic [55:0]  trial_reg;
    logic [32:0]  nd_reg;
    logic         nclamp_reg;
    logic [31:0]  regout_c_reg;
    fcds_result_t res_reg;

    logic [4:0]   eff_fw, eff_iw;
    logic [15:0]  imask, fmask;

    logic [15:0]  ld_ifield, ld_fdiv;
    logic [16:0]  ld_idiv;
    logic [32:0]  ld_divider;

    logic [55:0]  target56;
    logic [56:0]  adj_d;

    logic [56:0]  pk_idiv, pk_hw_full;
    logic [15:0]  pk_fdiv, pk_hw;
    logic         pk_clamp;
    logic [16:0]  pk_nidiv;
    logic [32:0]  pk_nd;
    logic         pk_fail;
    logic [31:0]  imask_sh, fmask_sh, pk_regout;

    logic         fn_inexact;
    logic         recalc_bad, set_bad;

    assign eff_fw = (cfg.frac_width > FIELD_MAX_W) ? FIELD_MAX_W : cfg.frac_width;
    assign eff_iw = (cfg.int_width > FIELD_MAX_W) ? FIELD_MAX_W : cfg.int_width;
    assign imask  = 16'((17'd1 << eff_iw) - 17'd1);
    assign fmask  = 16'((17'd1 << eff_fw) - 17'd1);

    // register word decode
    assign ld_ifield  = 16'(reg_in_reg >> cfg.int_shift) & imask;
    assign ld_fdiv    = 16'(reg_in_reg >> cfg.frac_shift) & fmask;
    assign ld_idiv    = {1'b0, ld_ifield} + {16'd0, !cfg.zero_based};
    assign ld_divider = (33'(ld_idiv) << eff_fw) | 33'(ld_fdiv);

    // rounding correction
    assign target56 = 56'(target_reg);
    always_comb begin
        adj_d = d_reg;
        if (rup_reg && (target56 < trial_reg)) begin
            adj_d = d_reg - 57'd1;
        end else if (rdn_reg && (target56 > trial_reg)) begin
            adj_d = d_reg + 57'd1;
        end
    end

    // clamp and repack
    assign pk_idiv    = d_reg >> eff_fw;
    assign pk_fdiv    = 16'(d_reg) & fmask;
    assign pk_hw_full = cfg.zero_based ? pk_idiv : pk_idiv - 57'd1;
    assign pk_clamp   = pk_hw_full > 57'(imask);
    assign pk_hw      = pk_clamp ? imask : pk_hw_full[15:0];
    assign pk_nidiv   = {1'b0, pk_hw} + {16'd0, !cfg.zero_based};
    assign pk_nd      = (33'(pk_nidiv) << eff_fw) | 33'(pk_fdiv);
    assign pk_fail    = (pk_idiv == 57'd0) || (pk_nd == 33'd0);
    assign imask_sh   = 32'(imask) << cfg.int_shift;
    assign fmask_sh   = 32'(fmask) << cfg.frac_shift;
    assign pk_regout  = (((reg_in_reg & ~imask_sh) | (32'(pk_hw) << cfg.int_shift))
                         & ~fmask_sh) | (32'(pk_fdiv) << cfg.frac_shift);

    assign fn_inexact = nclamp_reg && !rup_reg && !rdn_reg
                        && (target56 != div_rsp.quotient);
    assign recalc_bad = divider_reg == 33'd0;
    assign set_bad    = target_reg == 40'd0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (action_reg)
                    ACT_RECALC: state_next = recalc_bad ? ST_OUT : ST_WAIT_R;
                    ACT_SET:    state_next = set_bad ? ST_OUT : ST_WAIT_Q;
                    default:    state_next = ST_OUT;
                endcase
            end
            ST_WAIT_Q: begin
                if (div_rsp.done) begin
                    state_next = (div_rsp.quotient == '0) ? ST_ADJ : ST_WAIT_T;
                end
            end
            ST_WAIT_T: begin
                if (div_rsp.done) state_next = ST_ADJ;
            end
            ST_ADJ:  state_next = ST_PACK;
            ST_PACK: state_next = pk_fail ? ST_OUT : ST_WAIT_F;
            ST_WAIT_F, ST_WAIT_R: begin
                if (div_rsp.done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready         = 1'b0;
        out_valid        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = fin_reg;
        div_req.divisor  = '0;
        divider_next     = divider_reg;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DISPATCH: begin
                unique case (action_reg)
                    ACT_LOAD: divider_next = ld_divider;
                    ACT_RECALC: begin
                        div_req.start   = !recalc_bad;
                        div_req.divisor = 56'(divider_reg);
                    end
                    ACT_SET: begin
                        div_req.start   = !set_bad;
                        div_req.divisor = target56;
                    end
                    default: ;
                endcase
            end
            ST_WAIT_Q: begin
                div_req.start   = div_rsp.done && (div_rsp.quotient != '0);
                div_req.divisor = div_rsp.quotient;
            end
            ST_PACK: begin
                div_req.start   = !pk_fail;
                div_req.divisor = 56'(pk_nd);
            end
            ST_WAIT_F: begin
                if (div_rsp.done && !fn_inexact && !test_reg) divider_next = nd_reg;
            end
            ST_OUT: out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            divider_reg <= '0;
        end else begin
            state_reg   <= state_next;
            divider_reg <= divider_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    action_reg          <= in_item.action;
                    target_reg          <= in_item.target_freq;
                    reg_in_reg          <= in_item.reg_in;
                    rup_reg             <= in_item.round_up;
                    rdn_reg             <= in_item.round_down;
                    test_reg            <= in_item.test_run;
                    fin_reg             <= 56'(in_item.parent_freq) << eff_fw;
                    res_reg.freq_out    <= '0;
                    res_reg.status      <= STAT_OK;
                    res_reg.not_clamped <= 1'b1;
                    res_reg.reg_out     <= '0;
                    res_reg.reg_write   <= 1'b0;
                end
            end
            ST_DISPATCH: begin
                if (((action_reg == ACT_RECALC) && recalc_bad)
                    || ((action_reg == ACT_SET) && set_bad)) begin
                    res_reg.status <= STAT_INVALID;
                end
            end
            ST_WAIT_Q: begin
                if (div_rsp.done) begin
                    d_reg     <= {1'b0, div_rsp.quotient};
                    trial_reg <= '0;
                end
            end
            ST_WAIT_T: begin
                if (div_rsp.done) trial_reg <= div_rsp.quotient;
            end
            ST_ADJ: d_reg <= adj_d;
            ST_PACK: begin
                nd_reg       <= pk_nd;
                nclamp_reg   <= !pk_clamp;
                regout_c_reg <= pk_regout;
                if (pk_fail) res_reg.status <= STAT_INVALID;
            end
            ST_WAIT_R: begin
                if (div_rsp.done) res_reg.freq_out <= div_rsp.quotient;
            end
            ST_WAIT_F: begin
                if (div_rsp.done) begin
                    if (fn_inexact) begin
                        res_reg.status <= STAT_RANGE;
                    end else begin
                        res_reg.freq_out    <= div_rsp.quotient;
                        res_reg.not_clamped <= nclamp_reg;
                        if (!test_reg) begin
                            res_reg.reg_out   <= regout_c_reg;
                            res_reg.reg_write <= 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_result = res_reg;

endmodule

/* hw/rtl/fractional_clock_divider_setting.sv */
// ----------------------------------------------------------------------------
// Fractional clock divider setting: top level
// Configuration registers, sequencer with shared divider, output register.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+--------------------------------------
//   s_       | in  | s_tvalid/s_tready  | s_tdata item fields, s_tuser action
//   m_       | out | m_tvalid/m_tready  | m_tdata result fields, m_tuser status
//   cfg_     | in  | cfg_we             | cfg_addr register index, cfg_wdata
//
// The sequencer takes a new item only after the last one has left it.
// Each division is 56 shift steps, one quotient bit a cycle; set uses it
// at most three times, and skips the second when the first quotient is zero.
// Synchronous active-low reset restores the config, control state and divider.
// A stalled m_ side holds the result in the output register; the sequencer
// then holds in its output state and s_tready stays low.
// ----------------------------------------------------------------------------
module fractional_clock_divider_setting (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [fcds_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fcds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // parent_freq, target_freq, reg_in, round_up, round_down, test_run, pad
    input  logic [fcds_pkg::S_TDATA_W-1:0]   s_tdata,
    // action
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // freq_out, not_clamped, reg_out, reg_write, pad
    output logic [fcds_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [1:0]                       m_tuser
);
    import fcds_pkg::*;

    fcds_cfg_t     cfg_reg;
    fcds_item_t    in_item;
    fcds_result_t  ctrl_result;
    fcds_result_t  res_reg;
    fcds_div_req_t div_req;
    fcds_div_rsp_t div_rsp;
    logic          ctrl_valid;
    logic          out_ready;
    logic          m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.int_width  <= 5'd8;
            cfg_reg.frac_width <= 5'd0;
            cfg_reg.int_shift  <= 5'd0;
            cfg_reg.frac_shift <= 5'd16;
            cfg_reg.zero_based <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_INT_WIDTH:  cfg_reg.int_width  <= cfg_wdata;
                CFG_FRAC_WIDTH: cfg_reg.frac_width <= cfg_wdata;
                CFG_INT_SHIFT:  cfg_reg.int_shift  <= cfg_wdata;
                CFG_FRAC_SHIFT: cfg_reg.frac_shift <= cfg_wdata;
                CFG_ZERO_BASED: cfg_reg.zero_based <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign in_item.action      = fcds_action_t'(s_tuser);
    assign in_item.parent_freq = s_tdata[39:0];
    assign in_item.target_freq = s_tdata[79:40];
    assign in_item.reg_in      = s_tdata[111:80];
    assign in_item.round_up    = s_tdata[112];
    assign in_item.round_down  = s_tdata[113];
    assign in_item.test_run    = s_tdata[114];

    fcds_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .out_valid  (ctrl_valid),
        .out_ready  (out_ready),
        .out_result (ctrl_result),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    fcds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign out_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl_valid && out_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_valid && out_ready) res_reg <= ctrl_result;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_reg.reg_write, res_reg.reg_out,
                       res_reg.not_clamped, res_reg.freq_out};
    assign m_tuser  = res_reg.status;

endmodule

/* sim/fcds_result_checker.sv */
// ----------------------------------------------------------------------------
// Fractional clock divider setting: result checker
// Watches the register port and both stream channels, keeps its own copy of
// the divider settings and the stored divider, works out the result of every
// accepted item and compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
module fcds_result_checker
    import fcds_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [1:0]             m_tuser,
    output int unsigned            pending,
    output int unsigned            error_count
);

    fcds_cfg_t    cfg;
    logic [32:0]  div_q;
    fcds_result_t expected_q [$];
    int unsigned  errors;

    function automatic fcds_result_t predict_divider_result(input fcds_item_t it);
        fcds_result_t r;
        logic [31:0]  imask, fmask, word;
        logic [63:0]  fin, tgt, d, trial, ip, fp, hw, nd;
        int unsigned  iw, fw;
        r = '0;
        r.not_clamped = 1'b1;
        iw = (cfg.int_width > FIELD_MAX_W) ? 16 : cfg.int_width;
        fw = (cfg.frac_width > FIELD_MAX_W) ? 16 : cfg.frac_width;
        imask = (32'd1 << iw) - 32'd1;
        fmask = (32'd1 << fw) - 32'd1;
        fin = 64'(it.parent_freq) << fw;
        tgt = 64'(it.target_freq);
        case (it.action)
            ACT_LOAD: begin
                ip = 64'((it.reg_in >> cfg.int_shift) & imask);
                fp = 64'((it.reg_in >> cfg.frac_shift) & fmask);
                if (!cfg.zero_based) ip = ip + 64'd1;
                div_q = 33'((ip << fw) | fp);
            end
            ACT_RECALC: begin
                if (div_q == '0) r.status = STAT_INVALID;
                else r.freq_out = 56'(fin / 64'(div_q));
            end
            ACT_SET: begin
                if (tgt == 64'd0) begin
                    r.status = STAT_INVALID;
                end else begin
                    d = fin / tgt;
                    trial = (d != 64'd0) ? fin / d : 64'd0;
                    if (it.round_up && tgt < trial) d = d - 64'd1;
                    else if (it.round_down && tgt > trial) d = d + 64'd1;
                    ip = d >> fw;
                    fp = d & 64'(fmask);
                    if (ip == 64'd0) begin
                        r.status = STAT_INVALID;
                    end else begin
                        hw = cfg.zero_based ? ip : ip - 64'd1;
                        if (hw > 64'(imask)) begin
                            hw = 64'(imask);
                            r.not_clamped = 1'b0;
                        end
                        ip = cfg.zero_based ? hw : hw + 64'd1;
                        nd = (ip << fw) | fp;
                        if (nd == 64'd0) begin
                            r.status = STAT_INVALID;
                            r.not_clamped = 1'b1;
                        end else if (r.not_clamped && !it.round_up && !it.round_down
                                     && tgt != fin / nd) begin
                            r.status = STAT_RANGE;
                        end else begin
                            if (!it.test_run) begin
                                word = it.reg_in;
                                word &= ~(imask << cfg.int_shift);
                                word |= (hw[31:0] & imask) << cfg.int_shift;
                                word &= ~(fmask << cfg.frac_shift);
                                word |= (fp[31:0] & fmask) << cfg.frac_shift;
                                r.reg_out = word;
                                r.reg_write = 1'b1;
                                div_q = nd[32:0];
                            end
                            r.freq_out = 56'(fin / nd);
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        fcds_item_t   it;
        fcds_result_t got, want;
        if (!aresetn) begin
            cfg = '{5'd8, 5'd0, 5'd0, 5'd16, 1'b0};
            div_q = '0;
            expected_q.delete();
            errors = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_INT_WIDTH:  cfg.int_width  = cfg_wdata;
                    CFG_FRAC_WIDTH: cfg.frac_width = cfg_wdata;
                    CFG_INT_SHIFT:  cfg.int_shift  = cfg_wdata;
                    CFG_FRAC_SHIFT: cfg.frac_shift = cfg_wdata;
                    CFG_ZERO_BASED: cfg.zero_based = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.freq_out    = m_tdata[55:0];
                got.not_clamped = m_tdata[56];
                got.reg_out     = m_tdata[88:57];
                got.reg_write   = m_tdata[89];
                got.status      = m_tuser;
                if (expected_q.size() == 0) begin
                    $error("result transfer with no item outstanding: freq_out 0x%0h",
                           got.freq_out);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("freq_out", 64'(want.freq_out), 64'(got.freq_out));
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("not_clamped", 64'(want.not_clamped), 64'(got.not_clamped));
                    check_field("reg_out", 64'(want.reg_out), 64'(got.reg_out));
                    check_field("reg_write", 64'(want.reg_write), 64'(got.reg_write));
                end
            end
            if (s_tvalid && s_tready) begin
                it.action      = fcds_action_t'(s_tuser);
                it.parent_freq = s_tdata[39:0];
                it.target_freq = s_tdata[79:40];
                it.reg_in      = s_tdata[111:80];
                it.round_up    = s_tdata[112];
                it.round_down  = s_tdata[113];
                it.test_run    = s_tdata[114];
                expected_q.push_back(predict_divider_result(it));
            end
        end
        pending <= expected_q.size();
        error_count <= errors;
    end

endmodule

/* sim/fractional_clock_divider_setting_tb.sv */
// ----------------------------------------------------------------------------
// Fractional clock divider setting: testbench top
// Drives register writes and items with random gaps and receiver stalls,
// runs a directed set of corner cases and then random phases across several
// register settings, and reports the verdict from the result checker.
// ----------------------------------------------------------------------------
module fractional_clock_divider_setting_tb;
    import fcds_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 193;
    localparam int unsigned NUM_PHASES      = 10;
    localparam int unsigned RX_HOLD_CYCLES  = 600;
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam logic [39:0] FREQ_MAX        = 40'hFF_FFFF_FFFF;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [1:0]             m_tuser;
    int unsigned            pending;
    int unsigned            error_count;

    int unsigned            idle_pct = 0;
    int unsigned            rx_hold_count = 0;
    int unsigned            rx_hold_seen = 0;
    int unsigned            rx_wait = 0;
    int unsigned            quiet_cycles = 0;

    fractional_clock_divider_setting dut (.*);
    fcds_result_checker chk (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
            rx_hold_seen <= 0;
        end else if (rx_wait != 0) begin
            m_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else if (rx_hold_seen != rx_hold_count) begin
            m_tready <= 1'b0;
            rx_wait <= RX_HOLD_CYCLES - 1;
            rx_hold_seen <= rx_hold_count;
        end else if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
            m_tready <= 1'b0;
            rx_wait <= $urandom_range(0, 17);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("fractional_clock_divider_setting_tb failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64(input logic [63:0] lim);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return (lim == '1) ? r : r % (lim + 64'd1);
    endfunction

    function automatic logic [39:0] rand_freq();
        logic [39:0] v;
        v = 40'({$urandom, $urandom});
        return v >> $urandom_range(0, 39);
    endfunction

    function automatic fcds_item_t mk(input fcds_action_t a, input logic [39:0] p, t,
                                      input logic [31:0] r, input logic ru, rd, tr);
        fcds_item_t it;
        it.action = a;
        it.parent_freq = p;
        it.target_freq = t;
        it.reg_in = r;
        it.round_up = ru;
        it.round_down = rd;
        it.test_run = tr;
        return it;
    endfunction

    // mostly well-formed set requests: exact divisions and near misses
    function automatic fcds_item_t gen_item(input fcds_cfg_t c);
        fcds_item_t  it;
        logic [63:0] nd, m, lim, hi, base;
        int unsigned pick, ew, fwe;
        ew  = (c.int_width > FIELD_MAX_W) ? 16 : c.int_width;
        fwe = (c.frac_width > FIELD_MAX_W) ? 16 : c.frac_width;
        it = mk(ACT_SET, rand_freq(), rand_freq(), $urandom, 1'($urandom), 1'($urandom),
                $urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            it.action = ACT_LOAD;
        end else if (pick < 30) begin
            it.action = ACT_RECALC;
        end else if (pick < 33) begin
            it.action = ACT_NONE;
        end else if (pick < 90) begin
            nd = ((rand64(64'd1 << ew) + 64'd1) << fwe) | rand64((64'd1 << fwe) - 64'd1);
            if ($urandom_range(0, 1) == 1) nd = nd >> $urandom_range(0, ew + fwe);
            if (nd == 64'd0) nd = 64'd1;
            if (pick < 65) begin
                lim = 64'(FREQ_MAX) / nd;
                hi = 64'(FREQ_MAX) >> fwe;
                if (hi < lim) lim = hi;
                m = (rand64(lim - 64'd1) + 64'd1) >> $urandom_range(0, 32);
                if (m == 64'd0) m = 64'd1;
                it.parent_freq = 40'(m * nd);
                it.target_freq = 40'(m << fwe);
                it.round_up = $urandom_range(0, 3) == 0;
                it.round_down = $urandom_range(0, 3) == 0;
            end else begin
                base = (64'(it.parent_freq) << fwe) / nd;
                it.target_freq = 40'(base + 64'($urandom_range(0, 6)) - 64'd3);
            end
        end
        return it;
    endfunction

    task automatic send_item(input fcds_item_t it);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.action;
        s_tdata <= {5'd0, it.test_run, it.round_down, it.round_up, it.reg_in,
                    it.target_freq, it.parent_freq};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(input fcds_cfg_t c);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_INT_WIDTH;
        cfg_wdata <= c.int_width;
        @(posedge aclk);
        cfg_addr <= CFG_FRAC_WIDTH;
        cfg_wdata <= c.frac_width;
        @(posedge aclk);
        cfg_addr <= CFG_INT_SHIFT;
        cfg_wdata <= c.int_shift;
        @(posedge aclk);
        cfg_addr <= CFG_FRAC_SHIFT;
        cfg_wdata <= c.frac_shift;
        @(posedge aclk);
        cfg_addr <= CFG_ZERO_BASED;
        cfg_wdata <= {4'd0, c.zero_based};
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        fcds_cfg_t plan [NUM_PHASES];
        plan[0] = '{5'd8, 5'd0, 5'd0, 5'd16, 1'b0};
        plan[1] = '{5'd16, 5'd16, 5'd0, 5'd16, 1'b1};
        plan[2] = '{5'd1, 5'd0, 5'd31, 5'd31, 1'b0};
        plan[3] = '{5'd0, 5'd4, 5'd5, 5'd0, 1'b1};
        plan[4] = '{5'd31, 5'd31, 5'd16, 5'd0, 1'b0};
        plan[5] = '{5'd12, 5'd8, 5'd20, 5'd4, 1'b0};
        for (int p = 6; p < NUM_PHASES; p++) begin
            plan[p] = '{5'($urandom_range(1, 16)), 5'($urandom_range(0, 16)),
                        5'($urandom), 5'($urandom), 1'($urandom)};
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(mk(ACT_RECALC, 40'd1000, 40'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_SET, 40'd1000, 40'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_SET, 40'd0, 40'd5, 32'd0, 1'b0, 1'b1, 1'b0));
        send_item(mk(ACT_SET, 40'd0, 40'd5, 32'd0, 1'b1, 1'b0, 1'b0));
        send_item(mk(ACT_LOAD, 40'd0, 40'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_RECALC, FREQ_MAX, 40'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_LOAD, 40'd0, 40'd0, '1, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_RECALC, FREQ_MAX, 40'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_SET, 40'd1000, 40'd100, 32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_SET, 40'd1000, 40'd100, 32'hA5A5_A5A5, 1'b0, 1'b0, 1'b1));
        send_item(mk(ACT_SET, 40'd1000, 40'd300, 32'd0, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_SET, 40'd1000, 40'd300, 32'd0, 1'b1, 1'b0, 1'b0));
        send_item(mk(ACT_SET, 40'd1000, 40'd300, 32'd0, 1'b0, 1'b1, 1'b0));
        send_item(mk(ACT_SET, FREQ_MAX, 40'd1, 32'd0, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_SET, FREQ_MAX, 40'd1, 32'd0, 1'b1, 1'b0, 1'b0));
        send_item(mk(ACT_NONE, FREQ_MAX, FREQ_MAX, '1, 1'b1, 1'b1, 1'b1));
        send_item(mk(ACT_SET, FREQ_MAX, FREQ_MAX, '1, 1'b1, 1'b1, 1'b1));
        send_item(mk(ACT_LOAD, 40'd0, 40'd0, 32'h1234_5678, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_SET, 40'd1792, 40'd7, '1, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_SET, 40'd771, 40'd3, '1, 1'b0, 1'b0, 1'b0));
        send_item(mk(ACT_RECALC, 40'd771, 40'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_config(plan[p]);
            idle_pct <= (p == NUM_PHASES - 1 || p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
            send_item(mk(ACT_LOAD, 40'd0, 40'd0, 32'd1 << plan[p].frac_shift,
                         1'b0, 1'b0, 1'b0));
            send_item(mk(ACT_RECALC, FREQ_MAX, 40'd0, 32'd0, 1'b0, 1'b0, 1'b0));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 2 && n == 60) rx_hold_count <= rx_hold_count + 1;
                if (p == 4 && n == 90) drain();
                send_item(gen_item(plan[p]));
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (error_count == 0 && pending == 0) begin
            $display("fractional_clock_divider_setting_tb passed");
        end else begin
            $display("fractional_clock_divider_setting_tb failed");
        end
        $finish;
    end

endmodule

/* fractional_clock_divider_setting.f */
+incdir+hw/rtl
hw/rtl/fcds_pkg.sv
hw/rtl/fcds_div.sv
hw/rtl/fcds_ctrl.sv
hw/rtl/fractional_clock_divider_setting.sv
sim/fcds_result_checker.sv
sim/fractional_clock_divider_setting_tb.sv
